// ===== rtl/core/lis_pkg.sv =====
// ----------------------------------------------------------------------------
// lis_pkg
// Shared sizes, types and helpers for the longest increasing subsequence block.
// ----------------------------------------------------------------------------
package lis_pkg;

    // Store capacity and stored value width
    localparam int MAX_ELEMENTS = 128;
    localparam int VALUE_WIDTH  = 32;

    // Fixed port field widths
    localparam int IN_VALUE_W = 32;
    localparam int OUT_LEN_W  = 8;

    // Element count spans 0..MAX_ELEMENTS; a run length never exceeds the count
    localparam int CNT_W   = $clog2(MAX_ELEMENTS + 1);
    localparam int LEN_W   = CNT_W;
    localparam int IDX_W   = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CLAMP_W = (LEN_W > OUT_LEN_W) ? LEN_W : OUT_LEN_W;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } lis_state_t;

    typedef logic signed [VALUE_WIDTH-1:0] lis_value_t;
    typedef logic        [LEN_W-1:0]       lis_len_t;
    typedef logic        [CNT_W-1:0]       lis_cnt_t;

    // Saturate an internal length onto the 8-bit output field
    function automatic logic [OUT_LEN_W-1:0] clamp_len(input lis_len_t len);
        logic [CLAMP_W-1:0] wide;
        wide = CLAMP_W'(len);
        if (wide > CLAMP_W'((1 << OUT_LEN_W) - 1))
        begin
            return '1;
        end
        return wide[OUT_LEN_W-1:0];
    endfunction

endpackage

// ===== rtl/core/longest_increasing_subsequence_top.sv =====
// Timing: an accepted item passes ST_IDLE, then ST_SCAN over the stored elements
// (none when the store is empty or full), then ST_WRITE, which registers its result.
// A new item is taken only in ST_IDLE, after the last result is registered; the scan
// reads one stored entry per cycle; ST_WRITE waits on m_tready if a result is held.
// Reset clears the element count, best length and handshake state; the memory is
// not cleared, since only entries written in the current sequence are ever read.
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_top
// Incremental quadratic LIS: each item not dropped scans all stored entries in memory.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input item stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [lis_pkg::IN_VALUE_W-1:0]       s_tdata,   // [31:0] value
    input  logic                                 s_tlast,   // last
    // Result item stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [2*lis_pkg::OUT_LEN_W-1:0]      m_tdata,   // [7:0] ending_length,
                                                            // [15:8] best_length
    output logic                                 m_tuser,   // dropped
    output logic                                 m_tlast    // final_res
);
    import lis_pkg::*;

    // Sequencer and scan state
    lis_state_t state_reg, state_next;
    lis_cnt_t   count_reg, count_next;
    lis_len_t   best_reg, best_next;
    lis_cnt_t   scan_reg, scan_next;
    lis_len_t   run_reg, run_next;
    lis_value_t value_reg, value_next;
    logic       last_reg, last_next;
    logic       drop_reg, drop_next;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_LEN_W-1:0]   out_end_reg, out_end_next;
    logic [OUT_LEN_W-1:0]   out_best_reg, out_best_next;
    logic                   out_drop_reg, out_drop_next;
    logic                   out_last_reg, out_last_next;

    // Memory
    lis_value_t value_mem [MAX_ELEMENTS];
    lis_len_t   len_mem   [MAX_ELEMENTS];
    lis_value_t rd_value_reg;
    lis_len_t   rd_len_reg;
    logic       rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic       wr_en;
    logic [IDX_W-1:0] wr_addr;

    logic       in_accept;
    logic       out_free;
    lis_len_t   best_cand;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign best_cand = (run_reg > best_reg) ? run_reg : best_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (count_reg == '0 || count_reg == CNT_W'(MAX_ELEMENTS))
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_reg == count_reg)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        s_tready       = (state_reg == ST_IDLE);
        count_next     = count_reg;
        best_next      = best_reg;
        scan_next      = scan_reg;
        run_next       = run_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_end_next   = out_end_reg;
        out_best_next  = out_best_reg;
        out_drop_next  = out_drop_reg;
        out_last_next  = out_last_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = count_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                // Latch the item and issue the first read
                if (in_accept)
                begin
                    value_next = VALUE_WIDTH'(signed'(s_tdata));
                    last_next  = s_tlast;
                    drop_next  = (count_reg == CNT_W'(MAX_ELEMENTS));
                    run_next   = LEN_W'(1);
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    scan_next  = CNT_W'(1);
                end
            end
            ST_SCAN:
            begin
                // Fold in the entry read last cycle, issue the next read
                if (rd_value_reg < value_reg && rd_len_reg >= run_reg)
                begin
                    run_next = rd_len_reg + LEN_W'(1);
                end
                if (scan_reg != count_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = scan_reg[IDX_W-1:0];
                    scan_next = scan_reg + CNT_W'(1);
                end
            end
            ST_WRITE:
            begin
                // Store the element unless dropped, form the result, close the sequence on last
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_drop_next  = drop_reg;
                    out_last_next  = last_reg;
                    if (drop_reg)
                    begin
                        out_end_next  = '0;
                        out_best_next = clamp_len(best_reg);
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                        best_next     = best_cand;
                        out_end_next  = clamp_len(run_reg);
                        out_best_next = clamp_len(best_cand);
                    end
                    if (last_reg)
                    begin
                        count_next = '0;
                        best_next  = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_best_reg, out_end_reg};
    assign m_tuser  = out_drop_reg;
    assign m_tlast  = out_last_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        run_reg      <= run_next;
        value_reg    <= value_next;
        last_reg     <= last_next;
        drop_reg     <= drop_next;
        out_end_reg  <= out_end_next;
        out_best_reg <= out_best_next;
        out_drop_reg <= out_drop_next;
        out_last_reg <= out_last_next;
    end

    // Value/length memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            value_mem[wr_addr] <= value_reg;
            len_mem[wr_addr]   <= run_reg;
        end
        if (rd_en)
        begin
            rd_value_reg <= value_mem[rd_addr];
            rd_len_reg   <= len_mem[rd_addr];
        end
    end

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("element count beyond capacity");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_reg <= count_reg))
        else $error("scan address passed the element count");

    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[OUT_LEN_W-1:0] == '0))
        else $error("dropped item carries a nonzero length");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE && out_free && last_reg) |=>
            (count_reg == '0 && best_reg == '0))
        else $error("sequence not cleared after last item");

endmodule
